[design/multicart_outer_bank_register_unit_defines.svh]
// Assertion macros for the checker file of the outer bank register unit.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef MULTICART_OUTER_BANK_REGISTER_UNIT_DEFINES_SVH
`define MULTICART_OUTER_BANK_REGISTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MOBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mobr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MOBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mobr check failed");

`endif

[design/mobr_pkg.sv]
// Types and constants for the multicart outer bank register unit.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package mobr_pkg;

    typedef logic [1:0]  mode_t;
    typedef logic [1:0]  action_t;
    typedef logic [1:0]  cfg_index_t;
    typedef logic [11:0] cfg_data_t;
    typedef logic [11:0] bank_t;
    typedef logic [15:0] addr_t;
    typedef logic [7:0]  byte_t;

    // Beat kinds
    localparam mode_t MODE_WRITE   = 2'd0;
    localparam mode_t MODE_READ    = 2'd1;
    localparam mode_t MODE_PRG     = 2'd2;
    localparam mode_t MODE_CHR     = 2'd3;

    // Result dispositions
    localparam action_t ACT_HERE   = 2'd0;
    localparam action_t ACT_INNER  = 2'd1;
    localparam action_t ACT_WRAM   = 2'd2;
    localparam action_t ACT_IGNORE = 2'd3;

    // Configuration register indexes
    localparam cfg_index_t CFG_DIP_USED   = 2'd0;
    localparam cfg_index_t CFG_DIP_VALUE  = 2'd1;
    localparam cfg_index_t CFG_CHR_RAM_8K = 2'd2;

    // Outer register reset values
    localparam byte_t REG0_RESET = 8'h00;
    localparam byte_t REG1_RESET = 8'h00;
    localparam byte_t REG2_RESET = 8'h0F;
    localparam byte_t REG3_RESET = 8'h00;

    // Dip settings that pick the PRG enable bit
    localparam cfg_data_t DIP_EN_REG1_B7 = 12'd1;
    localparam cfg_data_t DIP_EN_REG2_B6 = 12'd2;
    localparam cfg_data_t DIP_EN_REG1_B6 = 12'd3;
    localparam cfg_data_t DIP_EN_REG2_B5 = 12'd4;

    // Lock bit in the fourth outer register
    localparam int LOCK_BIT = 6;

endpackage

[design/multicart_outer_bank_register_unit.sv]
// Top level of the multicart outer bank register unit.
// Depends on mobr_pkg; checked by mobr_checker (bound in its own file).
`timescale 1ns / 1ps

// Outer bank logic of a mapper 45 style multicart. Every input beat is one
// bus event: a CPU write (mode 0), a CPU read (mode 1), a PRG bank lookup
// (mode 2) or a CHR bank lookup (mode 3), and every input beat yields
// exactly one output beat, in order. CPU writes to 0x6000-0x7FFF load the
// four outer registers in turn through a 2-bit pointer until bit 6 of the
// fourth register is set, after which they are ignored; writes at 0x8000
// and up come back with action 1 for the inner controller. Reads in
// 0x5000-0x5FFF return the dip bit when the dip switch is in use, any
// other read comes back as action 2 (work RAM). PRG lookups merge the
// inner bank with a base and mask from registers 1-3 and report the
// dip-selected enable; CHR lookups merge with registers 0 and 2, or give
// the 1K slot of the PPU address when 8K CHR RAM is configured.
// Timing: two stages, an input register and a result register, with the
// whole translation between them; one beat is accepted every cycle while
// the output is not stalled. The outer registers are updated as a beat
// moves into the result register, so each beat sees the effect of all
// earlier ones.
// Configuration (cfg_write/cfg_index/cfg_data) is meant for idle periods
// only; index 3 is ignored. No start-up sweep: ready straight out of reset.
module multicart_outer_bank_register_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  mobr_pkg::cfg_index_t  cfg_index,
    input  mobr_pkg::cfg_data_t   cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mobr_pkg::mode_t       mode,
    input  mobr_pkg::addr_t       address,
    input  mobr_pkg::byte_t       value,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output mobr_pkg::bank_t       bank,
    output logic                  bank_enabled,
    output logic                  read_data,
    output mobr_pkg::action_t     action,
    output logic                  banks_changed
);

    import mobr_pkg::*;

    // configuration
    logic      dip_used_reg;
    cfg_data_t dip_value_reg;
    logic      chr_ram_8k_reg;

    // outer registers and write pointer
    byte_t       outer_reg [4];
    logic [1:0]  wr_ptr_reg;

    // input stage
    logic  s1_valid_reg;
    mode_t s1_mode_reg;
    addr_t s1_addr_reg;
    byte_t s1_value_reg;

    // result stage
    logic    out_valid_reg;
    bank_t   bank_reg;
    logic    enabled_reg;
    logic    rdata_reg;
    action_t action_reg;
    logic    changed_reg;

    // translation results
    bank_t   bank_next;
    logic    enabled_next;
    logic    rdata_next;
    action_t action_next;
    logic    changed_next;

    logic out_load;
    logic in_take;
    logic s1_move;
    logic reg_write;
    logic prg_en;
    byte_t chr_mask;

    // Result register frees when empty or being taken this edge.
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_used_reg   <= 1'b0;
            dip_value_reg  <= '0;
            chr_ram_8k_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DIP_USED:   dip_used_reg   <= cfg_data[0];
                CFG_DIP_VALUE:  dip_value_reg  <= cfg_data;
                CFG_CHR_RAM_8K: chr_ram_8k_reg <= cfg_data[0];
                default:        ;   // unused index
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg  <= mode;
            s1_addr_reg  <= address;
            s1_value_reg <= value;
        end
    end

    // ------------------------------------------------------------------
    // Translation
    // ------------------------------------------------------------------
    // PRG enable: the dip setting picks which outer register bit disables it.
    always_comb
    begin
        prg_en = 1'b1;
        if (dip_used_reg)
        begin
            unique case (dip_value_reg)
                DIP_EN_REG1_B7: prg_en = !outer_reg[1][7];
                DIP_EN_REG2_B6: prg_en = !outer_reg[2][6];
                DIP_EN_REG1_B6: prg_en = !outer_reg[1][6];
                DIP_EN_REG2_B5: prg_en = !outer_reg[2][5];
                default:        prg_en = 1'b1;
            endcase
        end
    end

    // CHR mask: low nibble of register 2 sets how many inner bits pass.
    assign chr_mask = 8'hFF >> (~outer_reg[2][3:0]);

    always_comb
    begin
        bank_next    = '0;
        enabled_next = 1'b0;
        rdata_next   = 1'b0;
        action_next  = ACT_HERE;
        changed_next = 1'b0;
        unique case (s1_mode_reg)
            MODE_WRITE:
            begin
                if (s1_addr_reg[15:13] == 3'b011)           // 0x6000-0x7FFF
                begin
                    if (!outer_reg[3][LOCK_BIT])
                    begin
                        changed_next = 1'b1;
                    end
                    else
                    begin
                        action_next = ACT_IGNORE;
                    end
                end
                else if (s1_addr_reg[15])                    // 0x8000 and up
                begin
                    action_next = ACT_INNER;
                end
                else
                begin
                    action_next = ACT_IGNORE;
                end
            end
            MODE_READ:
            begin
                if (dip_used_reg && s1_addr_reg[15:12] == 4'h5)
                begin
                    rdata_next = |(~dip_value_reg & s1_addr_reg[11:0]);
                end
                else
                begin
                    action_next = ACT_WRAM;
                end
            end
            MODE_PRG:
            begin
                bank_next    = {2'b00, outer_reg[2][7:6], outer_reg[1]}
                             | {6'b0, s1_value_reg[5:0] & ~outer_reg[3][5:0]};
                enabled_next = prg_en;
            end
            MODE_CHR:
            begin
                if (chr_ram_8k_reg)
                begin
                    bank_next = {9'b0, s1_addr_reg[12:10]};     // 1K slot
                end
                else
                begin
                    bank_next = {outer_reg[2][7:4], outer_reg[0]}
                              | {4'b0, s1_value_reg & chr_mask};
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outer registers: written as the beat moves to the result stage
    // ------------------------------------------------------------------
    assign reg_write = s1_move && changed_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_reg[0] <= REG0_RESET;
            outer_reg[1] <= REG1_RESET;
            outer_reg[2] <= REG2_RESET;
            outer_reg[3] <= REG3_RESET;
            wr_ptr_reg   <= '0;
        end
        else if (reg_write)
        begin
            outer_reg[wr_ptr_reg] <= s1_value_reg;
            wr_ptr_reg            <= wr_ptr_reg + 2'd1;
        end
    end

    // ------------------------------------------------------------------
    // Result stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            bank_reg    <= bank_next;
            enabled_reg <= enabled_next;
            rdata_reg   <= rdata_next;
            action_reg  <= action_next;
            changed_reg <= changed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bank          = bank_reg;
    assign bank_enabled  = enabled_reg;
    assign read_data     = rdata_reg;
    assign action        = action_reg;
    assign banks_changed = changed_reg;

endmodule

[design/mobr_checker.sv]
// Port-level checker for the multicart outer bank register unit, plus its bind.
// Depends on mobr_pkg and multicart_outer_bank_register_unit_defines.svh.
`timescale 1ns / 1ps
`include "multicart_outer_bank_register_unit_defines.svh"

module mobr_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input mobr_pkg::bank_t      bank,
    input logic                 bank_enabled,
    input logic                 read_data,
    input mobr_pkg::action_t    action,
    input logic                 banks_changed
);

    import mobr_pkg::*;

    // stalled result beat holds
    `MOBR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(bank) && $stable(action) && $stable(banks_changed))

    // a register update is always handled locally
    `MOBR_ASSERT_IMPLY(a_change_here, clk, rst_n, out_valid && banks_changed, action == ACT_HERE && bank == '0 && !bank_enabled && !read_data)

    // dip bit only on a handled read, never with a bank result
    `MOBR_ASSERT_IMPLY(a_rdata_here, clk, rst_n, out_valid && read_data, action == ACT_HERE && bank == '0 && !bank_enabled)

    // forwarded or ignored beats carry no other result
    `MOBR_ASSERT_IMPLY(a_fwd_clean, clk, rst_n, out_valid && action != ACT_HERE, bank == '0 && !bank_enabled && !read_data && !banks_changed)

endmodule

bind multicart_outer_bank_register_unit mobr_checker u_mobr_checker (.*);
